/* rtl/e2q_pkg.sv */
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants and types for the Euler angle to quaternion core.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int unsigned AngleWidth    = 16;
  localparam int unsigned QuatWidth     = 16;
  localparam int unsigned CordicStages  = 16;
  localparam int unsigned MaxStages     = 31;

  // CORDIC datapath, Q2.30 plus headroom
  localparam int unsigned CW = 34;

  localparam logic signed [CW-1:0] CordK     = 34'sd652032874;
  localparam logic signed [CW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] PiQ30     = 34'sd3373259426;

  function automatic logic signed [CW-1:0] atan_q30(input int unsigned idx);
    logic signed [CW-1:0] r;
    r = '0;
    case (idx)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      default: begin
        if (idx < MaxStages) r = 34'sd1 <<< (30 - idx);
      end
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
  } cordic_t;

endpackage

/* rtl/euler_to_quaternion_core.sv */
// Pipeline: the CORDIC fold and stage registers, then the e2q_combine product and sum registers.
// Throughput: one item per cycle; the pipeline advances whenever its last
// stage is empty or the result is taken.
// Reset: rst_ni clears the valid bits only; no datapath state is kept.
// ----------------------------------------------------------------------------
// euler_to_quaternion_core
// ZYX Euler angles to unit quaternion, pipelined CORDIC and product stages.
// ----------------------------------------------------------------------------
module euler_to_quaternion_core #(
  parameter int unsigned ANGLE_WIDTH   = e2q_pkg::AngleWidth,
  parameter int unsigned QUAT_WIDTH    = e2q_pkg::QuatWidth,
  parameter int unsigned CORDIC_STAGES = e2q_pkg::CordicStages
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // roll_angle, pitch_angle, yaw_angle from bit 0 up, zero padded
  input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // quat_w, quat_x, quat_y, quat_z from bit 0 up, zero padded
  output logic [((4*QUAT_WIDTH+7)/8)*8-1:0]  m_axis_tdata_o
);

  localparam int unsigned Depth = CORDIC_STAGES + 4;
  localparam int unsigned OW    = ((4*QUAT_WIDTH+7)/8)*8;
  localparam int unsigned CW    = e2q_pkg::CW;

  logic [Depth-1:0] vld_q;
  logic             en;
  logic signed [CW-1:0] sp, cp, st, ct, ss, cs;
  logic signed [QUAT_WIDTH-1:0] qw, qx, qy, qz;

  assign en = !vld_q[Depth-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid_i};
    end
  end

  e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk_i, .en_i(en), .angle_i(s_axis_tdata_i[ANGLE_WIDTH-1:0]), .sin_o(sp), .cos_o(cp)
  );
  e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk_i, .en_i(en), .angle_i(s_axis_tdata_i[2*ANGLE_WIDTH-1:ANGLE_WIDTH]),
    .sin_o(st), .cos_o(ct)
  );
  e2q_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk_i, .en_i(en), .angle_i(s_axis_tdata_i[3*ANGLE_WIDTH-1:2*ANGLE_WIDTH]),
    .sin_o(ss), .cos_o(cs)
  );

  e2q_combine #(.QUAT_WIDTH(QUAT_WIDTH)) u_combine (
    .clk_i, .en_i(en),
    .sp_i(sp), .cp_i(cp), .st_i(st), .ct_i(ct), .ss_i(ss), .cs_i(cs),
    .quat_w_o(qw), .quat_x_o(qx), .quat_y_o(qy), .quat_z_o(qz)
  );

  assign m_axis_tvalid_o = vld_q[Depth-1];
  assign m_axis_tdata_o  = OW'({qz, qy, qx, qw});

endmodule

/* rtl/e2q_cordic.sv */
// ----------------------------------------------------------------------------
// e2q_cordic
// Pipelined rotation CORDIC: half angle fold, then one register per stage.
// ----------------------------------------------------------------------------
module e2q_cordic #(
  parameter int unsigned ANGLE_WIDTH   = e2q_pkg::AngleWidth,
  parameter int unsigned CORDIC_STAGES = e2q_pkg::CordicStages
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [ANGLE_WIDTH-1:0]     angle_i,
  output logic signed [e2q_pkg::CW-1:0]     sin_o,
  output logic signed [e2q_pkg::CW-1:0]     cos_o
);

  localparam int unsigned CW = e2q_pkg::CW;

  e2q_pkg::cordic_t stage_q [CORDIC_STAGES+1];
  e2q_pkg::cordic_t fold_d;
  logic signed [CW-1:0] z0;

  always_comb begin
    z0 = CW'(angle_i) <<< (32 - ANGLE_WIDTH);
    fold_d.x   = e2q_pkg::CordK;
    fold_d.y   = '0;
    fold_d.z   = z0;
    fold_d.neg = 1'b0;
    if (z0 > e2q_pkg::HalfPiQ30) begin
      fold_d.z   = z0 - e2q_pkg::PiQ30;
      fold_d.neg = 1'b1;
    end else if (z0 < -e2q_pkg::HalfPiQ30) begin
      fold_d.z   = z0 + e2q_pkg::PiQ30;
      fold_d.neg = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) stage_q[0] <= fold_d;
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    e2q_pkg::cordic_t s_d;
    always_comb begin
      s_d.neg = stage_q[i].neg;
      if (!stage_q[i].z[CW-1]) begin
        s_d.x = stage_q[i].x - (stage_q[i].y >>> i);
        s_d.y = stage_q[i].y + (stage_q[i].x >>> i);
        s_d.z = stage_q[i].z - e2q_pkg::atan_q30(i);
      end else begin
        s_d.x = stage_q[i].x + (stage_q[i].y >>> i);
        s_d.y = stage_q[i].y - (stage_q[i].x >>> i);
        s_d.z = stage_q[i].z + e2q_pkg::atan_q30(i);
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) stage_q[i+1] <= s_d;
    end
  end

  assign cos_o = stage_q[CORDIC_STAGES].neg ? -stage_q[CORDIC_STAGES].x
                                            : stage_q[CORDIC_STAGES].x;
  assign sin_o = stage_q[CORDIC_STAGES].neg ? -stage_q[CORDIC_STAGES].y
                                            : stage_q[CORDIC_STAGES].y;

endmodule

/* rtl/e2q_combine.sv */
// ----------------------------------------------------------------------------
// e2q_combine
// Pair products, triple products, sum, round and saturate; three stages.
// ----------------------------------------------------------------------------
module e2q_combine #(
  parameter int unsigned QUAT_WIDTH = e2q_pkg::QuatWidth
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [e2q_pkg::CW-1:0] sp_i,
  input  logic signed [e2q_pkg::CW-1:0] cp_i,
  input  logic signed [e2q_pkg::CW-1:0] st_i,
  input  logic signed [e2q_pkg::CW-1:0] ct_i,
  input  logic signed [e2q_pkg::CW-1:0] ss_i,
  input  logic signed [e2q_pkg::CW-1:0] cs_i,
  output logic signed [QUAT_WIDTH-1:0]  quat_w_o,
  output logic signed [QUAT_WIDTH-1:0]  quat_x_o,
  output logic signed [QUAT_WIDTH-1:0]  quat_y_o,
  output logic signed [QUAT_WIDTH-1:0]  quat_z_o
);

  localparam int unsigned CW = e2q_pkg::CW;
  localparam int unsigned PW = 2 * CW;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned Sh = 60 - (QUAT_WIDTH - 2);

  logic signed [CW-1:0] cc_q, sst_q, cst_q, sct_q, ss_q, cs_q;
  logic signed [PW-1:0] p_q [8];
  logic signed [SW-1:0] s_q [4];

  function automatic logic signed [CW-1:0] mul30(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
    logic signed [PW-1:0] p;
    p = (PW'(a) * PW'(b)) + (PW'(1) <<< 29);
    return CW'(p >>> 30);
  endfunction

  function automatic logic signed [QUAT_WIDTH-1:0] to_out(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    logic signed [SW-1:0] one;
    r   = (v + (SW'(1) <<< (Sh - 1))) >>> Sh;
    one = SW'(1) <<< (QUAT_WIDTH - 2);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return QUAT_WIDTH'(r);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q  <= mul30(cp_i, ct_i);
      sst_q <= mul30(sp_i, st_i);
      cst_q <= mul30(cp_i, st_i);
      sct_q <= mul30(sp_i, ct_i);
      ss_q  <= ss_i;
      cs_q  <= cs_i;
      p_q[0] <= PW'(cc_q)  * PW'(cs_q);
      p_q[1] <= PW'(sst_q) * PW'(ss_q);
      p_q[2] <= PW'(sct_q) * PW'(cs_q);
      p_q[3] <= PW'(cst_q) * PW'(ss_q);
      p_q[4] <= PW'(cst_q) * PW'(cs_q);
      p_q[5] <= PW'(sct_q) * PW'(ss_q);
      p_q[6] <= PW'(cc_q)  * PW'(ss_q);
      p_q[7] <= PW'(sst_q) * PW'(cs_q);
      s_q[0] <= SW'(p_q[0]) + SW'(p_q[1]);
      s_q[1] <= SW'(p_q[2]) - SW'(p_q[3]);
      s_q[2] <= SW'(p_q[4]) + SW'(p_q[5]);
      s_q[3] <= SW'(p_q[6]) - SW'(p_q[7]);
    end
  end

  assign quat_w_o = to_out(s_q[0]);
  assign quat_x_o = to_out(s_q[1]);
  assign quat_y_o = to_out(s_q[2]);
  assign quat_z_o = to_out(s_q[3]);

endmodule
